// ----- rtl/core/ffab_pkg.sv -----
// shared constants, codes and the queue item type of the first-fit bump allocator
// depends on nothing; every other file of the block uses it by scoped names
`timescale 1ns / 1ps

package ffab_pkg;

  // buffer geometry
  localparam int BUFFER_BYTES = 4194304;
  localparam int ALIGN_BYTES  = 16;
  localparam int MAX_BUFFERS  = 16;

  // a fill count holds 0 .. BUFFER_BYTES
  localparam int FILL_W  = 23;
  localparam int ALIGN_W = 13;

  // largest request whose rounded size still fits a buffer
  localparam longint MAX_REQ = (longint'(BUFFER_BYTES) / ALIGN_BYTES) * ALIGN_BYTES;

  // reciprocal of the alignment, scaled by 2^FILL_W, for the remainder estimate
  localparam logic [FILL_W:0] RECIP =
    (FILL_W+1)'((64'd1 << FILL_W) / ALIGN_BYTES);

  // width used to compare a release index against the open count
  localparam int CMP_W = 8;

  // two-entry queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_TOO_BIG = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_t             kind;
    logic              too_big;
    logic [3:0]        rel;
    logic [FILL_W-1:0] aligned;
  } job_t;

endpackage

// ----- rtl/core/ffab_front.sv -----
// front part: accepts items, rounds the size up to the alignment, flags oversize
// depends on ffab_pkg
`timescale 1ns / 1ps

module ffab_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_kind,
  input  logic [31:0]   in_bytes,
  input  logic [3:0]    in_rel,
  output logic          job_valid,
  input  logic          job_ready,
  output ffab_pkg::job_t job
);

  localparam int FW = ffab_pkg::FILL_W;
  localparam logic [FW-1:0] ALIGN_F = FW'(ffab_pkg::ALIGN_BYTES);
  localparam logic [ffab_pkg::ALIGN_W-1:0] ALIGN_A =
    ffab_pkg::ALIGN_W'(ffab_pkg::ALIGN_BYTES);

  // stage 1: quotient estimate
  logic                s1_valid;
  ffab_pkg::kind_t     s1_kind;
  logic                s1_big;
  logic [3:0]          s1_rel;
  logic [FW-1:0]       s1_req;
  logic [FW-1:0]       s1_q;
  // stage 2: quotient times alignment
  logic                s2_valid;
  ffab_pkg::kind_t     s2_kind;
  logic                s2_big;
  logic [3:0]          s2_rel;
  logic [FW-1:0]       s2_req;
  logic [FW-1:0]       s2_qa;
  // stage 3: finished job waiting for the queue
  logic                s3_valid;
  ffab_pkg::job_t      s3_job;

  logic                advance;
  logic                big_in;
  logic [FW-1:0]       req_fit;
  logic [2*FW:0]       prod;
  logic [FW-1:0]       rem_est;
  logic [FW-1:0]       rem;
  logic [FW-1:0]       pad;

  // the whole pipe moves when the last stage is empty or drains
  assign advance  = !s3_valid || job_ready;
  assign in_ready = advance;

  // oversize check and clipped request
  assign big_in  = 64'(in_bytes) > 64'(ffab_pkg::MAX_REQ);
  assign req_fit = big_in ? '0 : in_bytes[FW-1:0];
  assign prod    = (2*FW+1)'(req_fit) * (2*FW+1)'(ffab_pkg::RECIP);

  // remainder with one correction step, then pad up to the next multiple
  always_comb begin
    rem_est = s2_req - s2_qa;
    rem     = (rem_est >= ALIGN_F) ? rem_est - ALIGN_F : rem_est;
    pad     = (rem != '0) ? ALIGN_F - rem : '0;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_kind <= ffab_pkg::kind_t'(in_kind);
      s1_big  <= big_in;
      s1_rel  <= in_rel;
      s1_req  <= req_fit;
      s1_q    <= prod[2*FW-1:FW];

      s2_kind <= s1_kind;
      s2_big  <= s1_big;
      s2_rel  <= s1_rel;
      s2_req  <= s1_req;
      s2_qa   <= FW'(s1_q * ALIGN_A);

      s3_job.kind    <= s2_kind;
      s3_job.too_big <= s2_big;
      s3_job.rel     <= s2_rel;
      s3_job.aligned <= s2_req + pad;
    end
  end

  assign job_valid = s3_valid;
  assign job       = s3_job;

endmodule

// ----- rtl/core/ffab_queue.sv -----
// two-entry queue that decouples the front and back parts
// depends on ffab_pkg
`timescale 1ns / 1ps

module ffab_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  ffab_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop,
  output ffab_pkg::job_t pop_job
);

  localparam int DEPTH = ffab_pkg::QUEUE_DEPTH;
  localparam int PW    = ffab_pkg::QPTR_W;

  ffab_pkg::job_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = count != (PW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_job    = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

endmodule

// ----- rtl/core/ffab_back.sv -----
// back part: first-fit scan over the fill counters, then grant or release and result
// depends on ffab_pkg
`timescale 1ns / 1ps

module ffab_back #(
  parameter int MAX_BUFFERS = ffab_pkg::MAX_BUFFERS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_pop,
  input  ffab_pkg::job_t job,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [3:0]     granted_buffer,
  output logic [21:0]    granted_offset,
  output logic [1:0]     status,
  output logic [4:0]     buffers_in_use
);

  localparam int FW = ffab_pkg::FILL_W;
  localparam int CW = $clog2(MAX_BUFFERS + 1);
  localparam int IW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int XW = ffab_pkg::CMP_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_COMMIT
  } bstate_t;

  bstate_t          state;
  ffab_pkg::job_t   cur;
  logic [FW-1:0]    fill [MAX_BUFFERS];
  logic [CW-1:0]    open_count;
  logic [MAX_BUFFERS-1:0] fit;
  logic [MAX_BUFFERS-1:0] fit_next;

  logic             commit_go;
  logic             found;
  logic [IW-1:0]    pick;
  logic             can_open;
  logic             opening;
  logic             alloc_ok;
  logic             rel_ok;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    addr;
  logic [FW-1:0]    rd;
  logic [FW-1:0]    base;
  logic [FW-1:0]    fill_new;
  logic             wr_en;
  logic             closing;
  logic [CW-1:0]    open_next;
  ffab_pkg::status_t st_next;

  // per-buffer fit test, each counter against the same rounded size
  always_comb begin
    for (int i = 0; i < MAX_BUFFERS; i++) begin
      fit_next[i] = (CW'(i) < open_count) &&
                    ((FW+1)'(fill[i]) + (FW+1)'(cur.aligned) <=
                     (FW+1)'(ffab_pkg::BUFFER_BYTES));
    end
  end

  // lowest buffer that fits
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = MAX_BUFFERS - 1; i >= 0; i--) begin
      if (fit[i]) begin
        found = 1'b1;
        pick  = IW'(i);
      end
    end
  end

  // grant, release and new open count
  always_comb begin
    can_open  = open_count < CW'(MAX_BUFFERS);
    alloc_ok  = !cur.too_big && (found || can_open);
    opening   = !cur.too_big && !found && can_open;
    idx       = found ? pick : open_count[IW-1:0];
    rel_ok    = XW'(cur.rel) < XW'(open_count);
    addr      = (cur.kind == ffab_pkg::KIND_ALLOC) ? idx : IW'(cur.rel);
    rd        = fill[addr];
    base      = opening ? '0 : rd;
    open_next = open_count;
    closing   = 1'b0;
    if (cur.kind == ffab_pkg::KIND_ALLOC) begin
      fill_new = base + cur.aligned;
      wr_en    = alloc_ok;
      if (opening) open_next = open_count + 1'b1;
      if (cur.too_big)   st_next = ffab_pkg::STATUS_TOO_BIG;
      else if (alloc_ok) st_next = ffab_pkg::STATUS_OK;
      else               st_next = ffab_pkg::STATUS_FULL;
    end else begin
      // an oversize release always empties the buffer
      fill_new = (!cur.too_big && (rd >= cur.aligned)) ? rd - cur.aligned : '0;
      wr_en    = rel_ok;
      closing  = rel_ok && (fill_new == '0) &&
                 (XW'(cur.rel) + XW'(1) == XW'(open_count));
      if (closing) open_next = open_count - 1'b1;
      st_next  = ffab_pkg::STATUS_OK;
    end
  end

  assign commit_go = (state == B_COMMIT) && (!out_valid || out_ready);
  assign job_pop   = job_valid && ((state == B_IDLE) || commit_go);

  // sequencer, allocator state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      out_valid  <= 1'b0;
      open_count <= '0;
      for (int i = 0; i < MAX_BUFFERS; i++) fill[i] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (job_pop) state <= B_SCAN;
        end
        B_SCAN: begin
          fit   <= fit_next;
          state <= B_COMMIT;
        end
        B_COMMIT: begin
          if (commit_go) begin
            if (wr_en) fill[addr] <= fill_new;
            open_count     <= open_next;
            out_valid      <= 1'b1;
            status         <= st_next;
            buffers_in_use <= 5'(open_next);
            if ((cur.kind == ffab_pkg::KIND_ALLOC) && alloc_ok) begin
              granted_buffer <= 4'(idx);
              granted_offset <= 22'(base);
            end else begin
              granted_buffer <= '0;
              granted_offset <= '0;
            end
            state <= job_pop ? B_SCAN : B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // current job
  always_ff @(posedge clk) begin
    if (job_pop) cur <= job;
  end

endmodule

// ----- rtl/core/first_fit_aligned_bump_allocator_top.sv -----
// top level of the first-fit aligned bump allocator: front, queue and back parts
// depends on ffab_pkg, ffab_front, ffab_queue, ffab_back
`timescale 1ns / 1ps
//
//  channel | signals                          | item
//  --------+----------------------------------+-------------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser | allocate or release request
//  m_      | m_tvalid m_tready m_tdata m_tuser | grant result, one per request
//
//  the back part handles each item in two states (B_SCAN registers the fit test
//  across all fill counters, B_COMMIT waits for the result register, then does the
//  priority pick and the counter update); a new item is taken only as the last one commits
//  the front runs a three-stage rounding pipeline; a two-entry queue lets the
//  front keep accepting while the back or the result register waits
//  synchronous reset clears every fill counter and the open count at once

module first_fit_aligned_bump_allocator_top #(
  parameter int MAX_BUFFERS = ffab_pkg::MAX_BUFFERS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // request_bytes[31:0], release_buffer[35:32], zero pad
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // granted_buffer[3:0], granted_offset[25:4],
                                 // buffers_in_use[30:26], zero pad
  output logic [1:0]  m_tuser    // status
);

  logic           job_valid;
  logic           job_ready;
  ffab_pkg::job_t job;
  logic           q_valid;
  logic           q_pop;
  ffab_pkg::job_t q_job;
  logic [3:0]     granted_buffer;
  logic [21:0]    granted_offset;
  logic [1:0]     status;
  logic [4:0]     buffers_in_use;

  ffab_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_bytes  (s_tdata[31:0]),
    .in_rel    (s_tdata[35:32]),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  ffab_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_job   (job),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_job    (q_job)
  );

  ffab_back #(
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (q_valid),
    .job_pop        (q_pop),
    .job            (q_job),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .granted_buffer (granted_buffer),
    .granted_offset (granted_offset),
    .status         (status),
    .buffers_in_use (buffers_in_use)
  );

  // result packing
  assign m_tdata = {1'b0, buffers_in_use, granted_offset, granted_buffer};
  assign m_tuser = status;

endmodule

// ----- tb/first_fit_aligned_bump_allocator_top_tb.sv -----
// self-checking testbench of the first-fit aligned bump allocator top level
// depends on ffab_pkg and first_fit_aligned_bump_allocator_top; directed table, then random runs
`timescale 1ns / 1ps

module first_fit_aligned_bump_allocator_top_tb;

  localparam int RANDOM_ITEMS = 450;
  localparam int TOTAL_ITEMS  = RANDOM_ITEMS + 35;

  // one grant as it leaves the block
  typedef struct packed {
    logic [3:0]        bidx;
    logic [21:0]       offset;
    ffab_pkg::status_t status;
    logic [4:0]        in_use;
  } grant_t;

  // one line of the directed table; want is used only when typed is set
  typedef struct packed {
    ffab_pkg::kind_t kind;
    logic [31:0]     bytes;
    logic [3:0]      idx;
    logic [4:0]      reps;
    logic            typed;
    grant_t          want;
  } probe_row_t;

  // a granted run, kept so that it can be handed back later
  typedef struct packed {
    logic [3:0]  bidx;
    logic [31:0] bytes;
  } run_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // request_bytes[31:0], release_buffer[35:32], zero pad
  logic        s_tuser = 1'b0;  // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;  // granted_buffer[3:0], granted_offset[25:4], buffers_in_use[30:26]
  logic [1:0]  m_tuser;  // status

  // shadow allocator state
  int unsigned fill_level [ffab_pkg::MAX_BUFFERS];
  int          open_bufs;

  grant_t      expected_grants[$];
  run_t        live_runs[$];
  probe_row_t  probe_rows[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  first_fit_aligned_bump_allocator_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // grant computed from the shadow state, which it updates
  function automatic grant_t step_allocator(ffab_pkg::kind_t k, logic [31:0] bytes,
                                            logic [3:0] idx);
    longint unsigned rounded;
    longint unsigned room;
    grant_t          g;
    int              slot;
    rounded = {32'd0, bytes};
    rounded = ((rounded + ffab_pkg::ALIGN_BYTES - 1) / ffab_pkg::ALIGN_BYTES) *
              ffab_pkg::ALIGN_BYTES;
    g = '0;
    g.status = ffab_pkg::STATUS_OK;
    slot = -1;
    if (k == ffab_pkg::KIND_ALLOC) begin
      if (rounded > ffab_pkg::BUFFER_BYTES) begin
        g.status = ffab_pkg::STATUS_TOO_BIG;
      end else begin
        // lowest open buffer with room, else open a new one
        for (int i = 0; i < open_bufs; i++) begin
          room = longint'(ffab_pkg::BUFFER_BYTES) - longint'(fill_level[i]);
          if (slot < 0 && room >= rounded) slot = i;
        end
        if (slot < 0 && open_bufs < ffab_pkg::MAX_BUFFERS) begin
          slot = open_bufs;
          fill_level[slot] = 0;
          open_bufs++;
        end
        if (slot < 0) begin
          g.status = ffab_pkg::STATUS_FULL;
        end else begin
          g.bidx = slot[3:0];
          g.offset = fill_level[slot][21:0];
          fill_level[slot] = fill_level[slot] + rounded[31:0];
        end
      end
    end else if (int'(idx) < open_bufs) begin
      // saturating release, only the last buffer closes
      if (longint'(fill_level[idx]) >= rounded) fill_level[idx] = fill_level[idx] - rounded[31:0];
      else fill_level[idx] = 0;
      if (fill_level[idx] == 0 && int'(idx) + 1 == open_bufs) open_bufs--;
    end
    g.in_use = open_bufs[4:0];
    return g;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("ERROR %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // idling pattern follows progress through the run
  task automatic pick_idling();
    int phase;
    phase = items_sent * 3 / TOTAL_ITEMS;
    if (phase == 0) begin
      send_idle_pct = 12;
      recv_stall_pct = 74;
    end else if (phase == 1) begin
      send_idle_pct = 74;
      recv_stall_pct = 12;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  endtask

  // offer one item and return at the edge that takes it; valid stays high
  task automatic offer_request(input ffab_pkg::kind_t k, input logic [31:0] bytes,
                               input logic [3:0] idx);
    pick_idling();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= {4'b0000, idx, bytes};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // send, predict and remember the run when it was granted
  task automatic issue_request(input ffab_pkg::kind_t k, input logic [31:0] bytes,
                               input logic [3:0] idx, input logic typed, input grant_t want);
    grant_t g;
    run_t   granted_run;
    offer_request(k, bytes, idx);
    g = step_allocator(k, bytes, idx);
    if (k == ffab_pkg::KIND_ALLOC && g.status == ffab_pkg::STATUS_OK) begin
      granted_run.bidx = g.bidx;
      granted_run.bytes = bytes;
      live_runs.insert(live_runs.size(), granted_run);
    end
    expected_grants.insert(expected_grants.size(), typed ? want : g);
  endtask

  task automatic add_row(input ffab_pkg::kind_t k, input logic [31:0] bytes,
                         input logic [3:0] idx, input int reps, input logic typed,
                         input grant_t want);
    probe_row_t row;
    row.kind = k;
    row.bytes = bytes;
    row.idx = idx;
    row.reps = reps[4:0];
    row.typed = typed;
    row.want = want;
    probe_rows.insert(probe_rows.size(), row);
  endtask

  function automatic grant_t mk(int bidx, int offset, ffab_pkg::status_t st, int in_use);
    grant_t g;
    g.bidx = bidx[3:0];
    g.offset = offset[21:0];
    g.status = st;
    g.in_use = in_use[4:0];
    return g;
  endfunction

  // result side: decode and compare with the oldest expectation
  task automatic check_grant();
    grant_t want;
    if (expected_grants.size() == 0) begin
      flag_mismatch($sformatf("grant with nothing expected: data %h status %0d", m_tdata, m_tuser));
    end else begin
      want = expected_grants.pop_front();
      if (m_tdata[3:0] != want.bidx)
        flag_mismatch($sformatf("granted_buffer %0d, expected %0d", m_tdata[3:0], want.bidx));
      if (m_tdata[25:4] != want.offset)
        flag_mismatch($sformatf("granted_offset %0d, expected %0d", m_tdata[25:4], want.offset));
      if (m_tuser != want.status)
        flag_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
      if (m_tdata[30:26] != want.in_use)
        flag_mismatch($sformatf("buffers_in_use %0d, expected %0d", m_tdata[30:26], want.in_use));
      if (m_tdata[31] !== 1'b0) flag_mismatch("result pad bit set");
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_grant();
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // stimulus
  initial begin
    grant_t          none;
    run_t            last_run;
    ffab_pkg::kind_t k;
    logic [31:0]     bytes;
    logic [3:0]      idx;
    int              alloc_bias;
    int              pick;
    int              sel;
    none = '0;
    for (int i = 0; i < ffab_pkg::MAX_BUFFERS; i++) fill_level[i] = 0;
    open_bufs = 0;

    // directed table
    add_row(ffab_pkg::KIND_ALLOC,   32'd0,         4'd0,  1,  1'b1,
            mk(0, 0, ffab_pkg::STATUS_OK, 1));
    add_row(ffab_pkg::KIND_ALLOC,   32'hFFFF_FFFF, 4'd0,  1,  1'b1,
            mk(0, 0, ffab_pkg::STATUS_TOO_BIG, 1));
    add_row(ffab_pkg::KIND_ALLOC,   32'd4194305,   4'd0,  1,  1'b1,
            mk(0, 0, ffab_pkg::STATUS_TOO_BIG, 1));
    add_row(ffab_pkg::KIND_ALLOC,   32'd1,         4'd0,  1,  1'b1,
            mk(0, 0, ffab_pkg::STATUS_OK, 1));
    add_row(ffab_pkg::KIND_ALLOC,   32'd4194304,   4'd0,  1,  1'b1,
            mk(1, 0, ffab_pkg::STATUS_OK, 2));
    add_row(ffab_pkg::KIND_ALLOC,   32'd4194289,   4'd0,  1,  1'b0, none);
    // zero length with buffers open
    add_row(ffab_pkg::KIND_ALLOC,   32'd0,         4'd0,  1,  1'b0, none);
    // release of a buffer that is not open
    add_row(ffab_pkg::KIND_RELEASE, 32'd100,       4'd5,  1,  1'b0, none);
    // inner buffer shrinks, then saturates at zero and stays open
    add_row(ffab_pkg::KIND_RELEASE, 32'd100,       4'd1,  1,  1'b0, none);
    add_row(ffab_pkg::KIND_RELEASE, 32'hFFFF_FFFF, 4'd1,  1,  1'b0, none);
    // last buffer empties and closes, then the next one down
    add_row(ffab_pkg::KIND_RELEASE, 32'd4194304,   4'd2,  1,  1'b0, none);
    add_row(ffab_pkg::KIND_RELEASE, 32'd0,         4'd1,  1,  1'b0, none);
    // fill the whole list, then overflow it
    add_row(ffab_pkg::KIND_ALLOC,   32'd4194304,   4'd0,  15, 1'b0, none);
    add_row(ffab_pkg::KIND_ALLOC,   32'd4194304,   4'd0,  1,  1'b1,
            mk(0, 0, ffab_pkg::STATUS_FULL, 16));
    add_row(ffab_pkg::KIND_ALLOC,   32'd16,        4'd0,  1,  1'b0, none);
    add_row(ffab_pkg::KIND_RELEASE, 32'hFFFF_FFFF, 4'd15, 1,  1'b0, none);
    add_row(ffab_pkg::KIND_RELEASE, 32'd5,         4'd15, 1,  1'b0, none);
    add_row(ffab_pkg::KIND_RELEASE, 32'd15,        4'd0,  1,  1'b0, none);
    // top offset in buffer zero
    add_row(ffab_pkg::KIND_ALLOC,   32'd4194288,   4'd0,  1,  1'b0, none);
    add_row(ffab_pkg::KIND_RELEASE, 32'd16,        4'd0,  1,  1'b0, none);
    add_row(ffab_pkg::KIND_ALLOC,   32'd16,        4'd0,  1,  1'b0, none);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probe_rows[r]) begin
      for (int n = 0; n < probe_rows[r].reps; n++) begin
        issue_request(probe_rows[r].kind, probe_rows[r].bytes, probe_rows[r].idx,
                      probe_rows[r].typed, probe_rows[r].want);
      end
    end
    live_runs.delete();

    // random runs: allocate with a bias redrawn every 50 items, hand back the newest run, some noise releases
    alloc_bias = 60;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) alloc_bias = $urandom_range(30, 90);
      pick = $urandom_range(0, 99);
      idx = 4'd0;
      if (pick < alloc_bias) begin
        k = ffab_pkg::KIND_ALLOC;
        sel = $urandom_range(0, 99);
        idx = $urandom_range(0, 15);
        if (sel < 35) bytes = $urandom_range(0, 300);
        else if (sel < 60) bytes = $urandom_range(301, 65536);
        else if (sel < 92) bytes = $urandom_range(65537, ffab_pkg::BUFFER_BYTES);
        else if (sel < 96) bytes = ffab_pkg::BUFFER_BYTES - $urandom_range(0, 31);
        else bytes = $urandom;
      end else if (pick < alloc_bias + (100 - alloc_bias) * 8 / 10 && live_runs.size() > 0) begin
        k = ffab_pkg::KIND_RELEASE;
        last_run = live_runs[live_runs.size() - 1];
        live_runs.delete(live_runs.size() - 1);
        idx = last_run.bidx;
        bytes = last_run.bytes;
      end else begin
        k = ffab_pkg::KIND_RELEASE;
        idx = $urandom_range(0, 15);
        bytes = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
      end
      issue_request(k, bytes, idx, 1'b0, none);
    end
    s_tvalid <= 1'b0;

    // drain, then allow for the pipeline latency
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ffab_pkg.sv
rtl/core/ffab_front.sv
rtl/core/ffab_queue.sv
rtl/core/ffab_back.sv
rtl/core/first_fit_aligned_bump_allocator_top.sv
tb/first_fit_aligned_bump_allocator_top_tb.sv
